FILE: rtl/msm7_pkg.sv
package msm7_pkg;

  localparam int ACC_W = 64;
  localparam int DEF_SAT_MASK_BITS = 64;
  localparam int DEF_SIG_MASK_BITS = 32;
  localparam int DEF_MAX_CELLS = 64;
  localparam int TRANSPORT_BITS = 24;
  localparam int RESERVED_BITS = 7;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [4:0] code_t;

  localparam code_t F_MSG_NUM     = 5'd0;
  localparam code_t F_STATION     = 5'd1;
  localparam code_t F_EPOCH       = 5'd2;
  localparam code_t F_MULTI       = 5'd3;
  localparam code_t F_IODS        = 5'd4;
  localparam code_t F_CLK_STEER   = 5'd5;
  localparam code_t F_EXT_CLK     = 5'd6;
  localparam code_t F_DIV_FREE    = 5'd7;
  localparam code_t F_SMOOTH      = 5'd8;
  localparam code_t F_SAT_MASK    = 5'd9;
  localparam code_t F_SIG_MASK    = 5'd10;
  localparam code_t F_CELL_MASK   = 5'd11;
  localparam code_t F_ROUGH_RANGE = 5'd12;
  localparam code_t F_EXT_INFO    = 5'd13;
  localparam code_t F_ROUGH_MOD   = 5'd14;
  localparam code_t F_ROUGH_RATE  = 5'd15;
  localparam code_t F_FINE_PR     = 5'd16;
  localparam code_t F_FINE_PHASE  = 5'd17;
  localparam code_t F_LOCK_TIME   = 5'd18;
  localparam code_t F_HALF_CYCLE  = 5'd19;
  localparam code_t F_CNR         = 5'd20;
  localparam code_t F_FINE_RATE   = 5'd21;
  localparam code_t F_ERROR       = 5'd22;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    code_t       code;
    logic [6:0]  sat;
    logic [5:0]  sig;
    logic [63:0] value;
    logic        last;
  } record_t;

  function automatic logic [6:0] fixed_width(input code_t code);
    logic [6:0] w;
    case (code)
      F_MSG_NUM:     w = 7'd12;
      F_STATION:     w = 7'd12;
      F_EPOCH:       w = 7'd30;
      F_MULTI:       w = 7'd1;
      F_IODS:        w = 7'd3;
      F_CLK_STEER:   w = 7'd2;
      F_EXT_CLK:     w = 7'd2;
      F_DIV_FREE:    w = 7'd1;
      F_SMOOTH:      w = 7'd3;
      F_ROUGH_RANGE: w = 7'd8;
      F_EXT_INFO:    w = 7'd4;
      F_ROUGH_MOD:   w = 7'd10;
      F_ROUGH_RATE:  w = 7'd14;
      F_FINE_PR:     w = 7'd20;
      F_FINE_PHASE:  w = 7'd24;
      F_LOCK_TIME:   w = 7'd10;
      F_HALF_CYCLE:  w = 7'd1;
      F_CNR:         w = 7'd10;
      F_FINE_RATE:   w = 7'd15;
      default:       w = 7'd0;
    endcase
    return w;
  endfunction

  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [6:0] c;
    c = '0;
    for (int i = 0; i < 64; i++) c = c + {6'd0, v[i]};
    return c;
  endfunction

  // position of the highest set bit, 0 when empty
  function automatic logic [5:0] top_bit(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) if (v[i]) p = 6'(i);
    return p;
  endfunction

endpackage

FILE: rtl/msm7_front.sv
module msm7_front
  import msm7_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  byte_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output byte_item_t out_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  byte_item_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != CNT_W'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/msm7_back.sv
module msm7_back
  import msm7_pkg::*;
#(
  parameter int SAT_MASK_BITS = DEF_SAT_MASK_BITS,
  parameter int SIG_MASK_BITS = DEF_SIG_MASK_BITS,
  parameter int MAX_CELLS     = DEF_MAX_CELLS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  byte_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output record_t    out_rec
);

  localparam int CW_W = $clog2(MAX_CELLS + 1);

  typedef enum logic [5:0] {
    M_IDLE  = 6'b000001,
    M_SKIP  = 6'b000010,
    M_FIELD = 6'b000100,
    M_SEEK  = 6'b001000,
    M_ERROR = 6'b010000,
    M_EMPTY = 6'b100000
  } mode_t;

  mode_t                  mode, mode_next;
  code_t                  field, field_next;
  logic [ACC_W-1:0]       acc, acc_next;
  logic [6:0]             held, held_next;
  logic [7:0]             byte_sr, byte_sr_next;
  logic [3:0]             bits_left, bits_left_next;
  logic [SAT_MASK_BITS-1:0] sat_mask, sat_mask_next;
  logic [SIG_MASK_BITS-1:0] sig_mask, sig_mask_next;
  logic [6:0]             nsat, nsat_next;
  logic [6:0]             ncell, ncell_next;
  logic [CW_W-1:0]        cellw, cellw_next;
  logic [MAX_CELLS-1:0]   cell_lj, cell_lj_next;
  logic [MAX_CELLS-1:0]   cell_walk, cell_walk_next;
  logic [SAT_MASK_BITS-1:0] sat_rem, sat_rem_next;
  logic [SIG_MASK_BITS-1:0] sig_rem, sig_rem_next;
  logic [6:0]             tag_sat, tag_sat_next;
  logic [5:0]             tag_sig, tag_sig_next;
  logic [6:0]             count, count_next;
  logic                   out_valid_next;
  record_t                rec_next;

  logic                   out_free;
  logic [ACC_W-1:0]       acc_shift;
  logic [6:0]             held_inc;
  logic [6:0]             width_cur;
  logic                   done;
  logic [6:0]             pc_acc;
  logic [5:0]             p_sat;
  logic [6:0]             sat_num;
  logic [SIG_MASK_BITS-1:0] sig_src;
  logic [5:0]             p_sig;
  logic [5:0]             sig_num;
  logic [12:0]            prod;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (bits_left == 4'd0) &&
                     (mode == M_IDLE || mode == M_SKIP || mode == M_FIELD);
  assign acc_shift = {acc[ACC_W-2:0], byte_sr[7]};
  assign held_inc  = held + 7'd1;
  assign pc_acc    = popcount64(acc_shift);
  assign p_sat     = top_bit(ACC_W'(sat_rem));
  assign sat_num   = 7'(SAT_MASK_BITS) - {1'b0, p_sat};
  assign sig_src   = (sig_rem == '0) ? sig_mask : sig_rem;
  assign p_sig     = top_bit(ACC_W'(sig_src));
  assign sig_num   = 6'(SIG_MASK_BITS) - p_sig;
  assign prod      = {6'd0, nsat} * {7'd0, pc_acc[5:0]};

  always_comb begin
    if (mode == M_SKIP) begin
      width_cur = (field == F_MSG_NUM) ? 7'(TRANSPORT_BITS) : 7'(RESERVED_BITS);
    end else begin
      case (field)
        F_SAT_MASK:  width_cur = 7'(SAT_MASK_BITS);
        F_SIG_MASK:  width_cur = 7'(SIG_MASK_BITS);
        F_CELL_MASK: width_cur = 7'(cellw);
        default:     width_cur = fixed_width(field);
      endcase
    end
  end

  assign done = (held_inc == width_cur);

  always_comb begin
    mode_next      = mode;
    field_next     = field;
    acc_next       = acc;
    held_next      = held;
    byte_sr_next   = byte_sr;
    bits_left_next = bits_left;
    sat_mask_next  = sat_mask;
    sig_mask_next  = sig_mask;
    nsat_next      = nsat;
    ncell_next     = ncell;
    cellw_next     = cellw;
    cell_lj_next   = cell_lj;
    cell_walk_next = cell_walk;
    sat_rem_next   = sat_rem;
    sig_rem_next   = sig_rem;
    tag_sat_next   = tag_sat;
    tag_sig_next   = tag_sig;
    count_next     = count;
    out_valid_next = out_valid && !out_ready;
    rec_next       = out_rec;

    if (mode == M_ERROR) begin
      if (out_free) begin
        out_valid_next = 1'b1;
        rec_next       = '{code: F_ERROR, sat: '0, sig: '0, value: '0, last: 1'b1};
        mode_next      = M_IDLE;
      end
    end else if (mode == M_EMPTY) begin
      // no cell mask bits on the wire: report an empty mask at once
      if (out_free) begin
        out_valid_next = 1'b1;
        rec_next = '{code: F_CELL_MASK, sat: '0, sig: '0, value: '0,
                     last: (nsat == 7'd0)};
        ncell_next = '0;
        acc_next   = '0;
        held_next  = '0;
        if (nsat != 7'd0) begin
          mode_next    = M_FIELD;
          field_next   = F_ROUGH_RANGE;
          count_next   = nsat;
          sat_rem_next = sat_mask;
        end else begin
          mode_next = M_IDLE;
        end
      end
    end else if (mode == M_SEEK) begin
      // advance the cell cursor by one position of the satellite x signal grid
      if (sig_rem == '0) begin
        sat_rem_next = sat_rem & ~(SAT_MASK_BITS'(1) << p_sat);
        tag_sat_next = sat_num;
      end
      sig_rem_next   = sig_src & ~(SIG_MASK_BITS'(1) << p_sig);
      tag_sig_next   = sig_num;
      cell_walk_next = cell_walk << 1;
      if (cell_walk[MAX_CELLS-1]) mode_next = M_FIELD;
    end else if (bits_left == 4'd0) begin
      if (in_valid) begin
        byte_sr_next   = in_item.data;
        bits_left_next = 4'd8;
        if (in_item.start) begin
          mode_next  = M_SKIP;
          field_next = F_MSG_NUM;
          acc_next   = '0;
          held_next  = '0;
          count_next = '0;
        end
      end
    end else if (out_free) begin
      byte_sr_next   = byte_sr << 1;
      bits_left_next = bits_left - 4'd1;
      if (mode == M_SKIP) begin
        held_next = held_inc;
        if (done) begin
          held_next = '0;
          acc_next  = '0;
          mode_next = M_FIELD;
        end
      end else if (mode == M_FIELD) begin
        acc_next  = acc_shift;
        held_next = held_inc;
        if (done) begin
          acc_next  = '0;
          held_next = '0;
          if (field inside {[F_MSG_NUM:F_SMOOTH]}) begin
            out_valid_next = 1'b1;
            rec_next = '{code: field, sat: '0, sig: '0, value: acc_shift, last: 1'b0};
            if (field == F_IODS) begin
              mode_next  = M_SKIP;
              field_next = F_CLK_STEER;
            end else begin
              field_next = field + 5'd1;
            end
          end else if (field == F_SAT_MASK) begin
            sat_mask_next  = acc_shift[SAT_MASK_BITS-1:0];
            nsat_next      = pc_acc;
            out_valid_next = 1'b1;
            rec_next = '{code: F_SAT_MASK, sat: '0, sig: '0, value: ACC_W'(pc_acc),
                         last: 1'b0};
            field_next = F_SIG_MASK;
          end else if (field == F_SIG_MASK) begin
            sig_mask_next  = acc_shift[SIG_MASK_BITS-1:0];
            out_valid_next = 1'b1;
            rec_next = '{code: F_SIG_MASK, sat: '0, sig: '0, value: ACC_W'(pc_acc),
                         last: 1'b0};
            if (prod > 13'(MAX_CELLS)) begin
              mode_next = M_ERROR;
            end else begin
              cellw_next = prod[CW_W-1:0];
              field_next = F_CELL_MASK;
              if (prod == 13'd0) mode_next = M_EMPTY;
            end
          end else if (field == F_CELL_MASK) begin
            cell_lj_next = acc_shift[MAX_CELLS-1:0] << (CW_W'(MAX_CELLS) - cellw);
            ncell_next   = pc_acc;
            out_valid_next = 1'b1;
            rec_next = '{code: F_CELL_MASK, sat: '0, sig: '0, value: ACC_W'(pc_acc),
                         last: (nsat == 7'd0) && (pc_acc == 7'd0)};
            if (nsat != 7'd0) begin
              field_next   = F_ROUGH_RANGE;
              count_next   = nsat;
              sat_rem_next = sat_mask;
            end else begin
              mode_next = M_IDLE;
            end
          end else begin
            out_valid_next = 1'b1;
            rec_next.code  = field;
            rec_next.value = acc_shift;
            rec_next.last  = (count == 7'd1) &&
                             ((field == F_FINE_RATE) ||
                              (field == F_ROUGH_RATE && ncell == 7'd0));
            if (field <= F_ROUGH_RATE) begin
              rec_next.sat = sat_num;
              rec_next.sig = '0;
              sat_rem_next = sat_rem & ~(SAT_MASK_BITS'(1) << p_sat);
            end else begin
              rec_next.sat = tag_sat;
              rec_next.sig = tag_sig;
            end
            count_next = count - 7'd1;
            if (count == 7'd1) begin
              if (field < F_ROUGH_RATE) begin
                field_next   = field + 5'd1;
                count_next   = nsat;
                sat_rem_next = sat_mask;
              end else if (field == F_FINE_RATE ||
                           (field == F_ROUGH_RATE && ncell == 7'd0)) begin
                mode_next = M_IDLE;
              end else begin
                // restart the cell cursor for the next group
                mode_next      = M_SEEK;
                field_next     = field + 5'd1;
                count_next     = ncell;
                sat_rem_next   = sat_mask;
                sig_rem_next   = '0;
                cell_walk_next = cell_lj;
              end
            end else if (field > F_ROUGH_RATE) begin
              mode_next = M_SEEK;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      field     <= F_MSG_NUM;
      held      <= '0;
      bits_left <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      acc       <= '0;
      sat_mask  <= '0;
      sig_mask  <= '0;
      nsat      <= '0;
      ncell     <= '0;
      cellw     <= '0;
    end else begin
      mode      <= mode_next;
      field     <= field_next;
      held      <= held_next;
      bits_left <= bits_left_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      acc       <= acc_next;
      sat_mask  <= sat_mask_next;
      sig_mask  <= sig_mask_next;
      nsat      <= nsat_next;
      ncell     <= ncell_next;
      cellw     <= cellw_next;
    end
  end

  always_ff @(posedge clk) begin
    byte_sr   <= byte_sr_next;
    cell_lj   <= cell_lj_next;
    cell_walk <= cell_walk_next;
    sat_rem   <= sat_rem_next;
    sig_rem   <= sig_rem_next;
    tag_sat   <= tag_sat_next;
    tag_sig   <= tag_sig_next;
    out_rec   <= rec_next;
  end

endmodule

FILE: rtl/gnss_msm7_message_field_decoder.sv
// channel  direction  word                                                   handshake
// s_*      in         frame byte (tdata), preamble flag (tuser)              tvalid/tready
// m_*      out        field record (tdata), field code (tuser), end (tlast)  tvalid/tready
//
// A byte is taken from the queue only once the previous one is fully shifted; its
// eight bits enter the field collector one per cycle while the output is free.
// Inside the cell groups the cell cursor first steps over the satellite x signal
// grid before each item, one step per cycle (at most MAX_CELLS steps per group).
// A full output register stalls the bit collector; the 4-word byte queue keeps
// the input open meanwhile. Synchronous reset puts the decoder idle.
module gnss_msm7_message_field_decoder
  import msm7_pkg::*;
#(
  parameter int SAT_MASK_BITS = DEF_SAT_MASK_BITS,
  parameter int SIG_MASK_BITS = DEF_SIG_MASK_BITS,
  parameter int MAX_CELLS     = DEF_MAX_CELLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // frame_byte
  input  logic        s_tuser,   // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // sat_number, sig_number, field_value, zero pad
  output logic [4:0]  m_tuser,   // field_code
  output logic        m_tlast    // last_field
);

  byte_item_t in_item;
  byte_item_t q_item;
  logic       q_valid;
  logic       q_ready;
  record_t    rec;

  assign in_item = '{start: s_tuser, data: s_tdata};

  msm7_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  msm7_back #(
    .SAT_MASK_BITS (SAT_MASK_BITS),
    .SIG_MASK_BITS (SIG_MASK_BITS),
    .MAX_CELLS     (MAX_CELLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (rec)
  );

  assign m_tdata = {3'd0, rec.value, rec.sig, rec.sat};
  assign m_tuser = rec.code;
  assign m_tlast = rec.last;

`ifndef NO_ASSERTIONS
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && rec.code == F_ERROR) |-> rec.last)
    else $error("error record without end of frame");

  a_cell_tagged: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && rec.code >= F_FINE_PR && rec.code <= F_FINE_RATE)
      |-> (rec.sat != 7'd0 && rec.sig != 6'd0))
    else $error("cell record without satellite and signal");

  a_header_untagged: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && rec.code <= F_CELL_MASK) |-> (rec.sat == 7'd0 && rec.sig == 6'd0))
    else $error("header record carries a tag");
`endif

endmodule

FILE: tb/gnss_msm7_message_field_decoder_test.sv
module gnss_msm7_message_field_decoder_test;
  import msm7_pkg::*;

  localparam int PH_TRANSPORT = 22;
  localparam int PH_RESERVED  = 23;
  localparam int PH_IDLE      = 31;
  localparam int MAX_CELL_CNT = 64;
  localparam int BYTE_TARGET  = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;

  gnss_msm7_message_field_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  byte_item_t pending_bytes[$];
  record_t    expected_records[$];
  bit         frame_bits[$];
  int         err_count = 0;
  int         bytes_sent = 0;
  logic       byte_taken = 1'b0;
  byte_item_t next_byte;

  // decoder shadow state
  logic [63:0] acc_bits;
  int          acc_count;
  int          phase;
  logic [63:0] sat_mask, sig_mask, cell_mask, left_bits;
  int          group_left;
  int          step_records;

  function automatic int field_bits(int ph);
    case (ph)
      0, 1: return 12;
      2: return 30;
      3, 7, 19: return 1;
      4, 8: return 3;
      5, 6: return 2;
      9: return 64;
      10: return 32;
      11: return $countones(sat_mask) * $countones(sig_mask);
      12: return 8;
      13: return 4;
      14, 18, 20: return 10;
      15: return 14;
      16: return 20;
      17, PH_TRANSPORT: return 24;
      21: return 15;
      PH_RESERVED: return 7;
      default: return 0;
    endcase
  endfunction

  function automatic int following(int ph);
    if (ph == PH_TRANSPORT) return 0;
    if (ph == F_IODS) return PH_RESERVED;
    if (ph == PH_RESERVED) return F_CLK_STEER;
    if (ph == F_FINE_RATE) return PH_IDLE;
    return ph + 1;
  endfunction

  function automatic int mask_member(logic [63:0] m, int w, int ordinal);
    int seen;
    seen = 0;
    for (int i = w - 1; i >= 0; i--) if (m[i]) begin
      if (seen == ordinal) return w - i;
      seen++;
    end
    return 0;
  endfunction

  task automatic add_record(int code, int sat, int sig, logic [63:0] val, bit last);
    record_t r;
    r.code = code_t'(code);
    r.sat = 7'(sat);
    r.sig = 6'(sig);
    r.value = val;
    r.last = last;
    expected_records.insert(expected_records.size(), r);
    step_records++;
  endtask

  task automatic enter_phase(int ph);
    forever begin
      phase = ph;
      acc_bits = '0;
      acc_count = 0;
      if (ph == F_CELL_MASK) begin
        if (field_bits(F_CELL_MASK) == 0) begin
          cell_mask = '0;
          add_record(F_CELL_MASK, 0, 0, 0, 0);
          ph = F_ROUGH_RANGE;
          continue;
        end
        return;
      end
      if (ph >= F_ROUGH_RANGE && ph <= F_FINE_RATE) begin
        left_bits = (ph <= F_ROUGH_RATE) ? sat_mask : cell_mask;
        group_left = $countones(left_bits);
        if (group_left == 0) begin
          ph = following(ph);
          continue;
        end
        return;
      end
      // flag the final word of the frame
      if (ph == PH_IDLE && step_records > 0)
        expected_records[expected_records.size() - 1].last = 1'b1;
      return;
    end
  endtask

  task automatic shift_bit(bit b);
    logic [63:0] v;
    int p, nsig, len, k, sat, sig;
    if (phase == PH_IDLE || phase >= 24) return;
    acc_bits = {acc_bits[62:0], b};
    acc_count++;
    if (acc_count < field_bits(phase)) return;
    v = acc_bits;
    if (phase == PH_TRANSPORT || phase == PH_RESERVED) begin
      enter_phase(following(phase));
    end else if (phase <= F_SMOOTH) begin
      add_record(phase, 0, 0, v, 0);
      enter_phase(following(phase));
    end else if (phase == F_SAT_MASK) begin
      sat_mask = v;
      add_record(F_SAT_MASK, 0, 0, $countones(v), 0);
      enter_phase(F_SIG_MASK);
    end else if (phase == F_SIG_MASK) begin
      sig_mask = v;
      add_record(F_SIG_MASK, 0, 0, $countones(v), 0);
      if (field_bits(F_CELL_MASK) > MAX_CELL_CNT) begin
        add_record(F_ERROR, 0, 0, 0, 1);
        phase = PH_IDLE;
        acc_bits = '0;
        acc_count = 0;
      end else begin
        enter_phase(F_CELL_MASK);
      end
    end else if (phase == F_CELL_MASK) begin
      cell_mask = v;
      add_record(F_CELL_MASK, 0, 0, $countones(v), 0);
      enter_phase(F_ROUGH_RANGE);
    end else begin
      p = 0;
      for (int i = 0; i < 64; i++) if (left_bits[i]) p = i;
      left_bits[p] = 1'b0;
      sig = 0;
      if (phase <= F_ROUGH_RATE) begin
        sat = 64 - p;
      end else begin
        nsig = $countones(sig_mask);
        len = field_bits(F_CELL_MASK);
        k = (p < len) ? len - 1 - p : 0;
        if (nsig == 0) nsig = 1;
        sat = mask_member(sat_mask, 64, k / nsig);
        sig = mask_member(sig_mask, 32, k % nsig);
      end
      add_record(phase, sat, sig, v, 0);
      if (group_left > 0) group_left--;
      if (group_left == 0) enter_phase(following(phase));
      else begin
        acc_bits = '0;
        acc_count = 0;
      end
    end
  endtask

  task automatic predict_byte(logic [7:0] d, logic start);
    step_records = 0;
    if (start) begin
      group_left = 0;
      left_bits = '0;
      enter_phase(PH_TRANSPORT);
    end
    for (int i = 7; i >= 0; i--) shift_bit(d[i]);
  endtask

  // frame building
  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_bits(int w, int k);
    logic [63:0] m;
    m = '0;
    if (k > w) k = w;
    while ($countones(m) < k) m[$urandom_range(w - 1)] = 1'b1;
    return m;
  endfunction

  task automatic put_bits(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) frame_bits.insert(frame_bits.size(), v[i]);
  endtask

  // fill: 0 random, 1 all ones, 2 all zeros
  task automatic put_field(int n, int fill);
    put_bits(fill == 1 ? '1 : fill == 2 ? '0 : rnd64(), n);
  endtask

  task automatic build_frame(logic [63:0] sm, logic [31:0] gm, logic [63:0] cm,
                             int fill, int keep_bytes);
    int ns, cw, nc, nbytes;
    logic [7:0] b;
    byte_item_t it;
    frame_bits.delete();
    put_bits(64'hD3, 8);
    put_field(16, fill);
    put_field(12, fill); put_field(12, fill); put_field(30, fill);
    put_field(1, fill); put_field(3, fill); put_field(7, fill);
    put_field(2, fill); put_field(2, fill); put_field(1, fill); put_field(3, fill);
    put_bits(sm, 64);
    put_bits({32'd0, gm}, 32);
    ns = $countones(sm);
    cw = ns * $countones(gm);
    if (cw > MAX_CELL_CNT) begin
      put_field(24, fill);
    end else begin
      put_bits(cm, cw);
      nc = $countones(cm);
      for (int i = 0; i < ns; i++) put_field(8, fill);
      for (int i = 0; i < ns; i++) put_field(4, fill);
      for (int i = 0; i < ns; i++) put_field(10, fill);
      for (int i = 0; i < ns; i++) put_field(14, fill);
      for (int i = 0; i < nc; i++) put_field(20, fill);
      for (int i = 0; i < nc; i++) put_field(24, fill);
      for (int i = 0; i < nc; i++) put_field(10, fill);
      for (int i = 0; i < nc; i++) put_field(1, fill);
      for (int i = 0; i < nc; i++) put_field(10, fill);
      for (int i = 0; i < nc; i++) put_field(15, fill);
    end
    while (frame_bits.size() % 8 != 0) frame_bits.insert(frame_bits.size(), 1'b0);
    nbytes = frame_bits.size() / 8;
    if (keep_bytes > 0 && keep_bytes < nbytes) nbytes = keep_bytes;
    for (int j = 0; j < nbytes; j++) begin
      for (int i = 0; i < 8; i++) b[7 - i] = frame_bits[8 * j + i];
      it.start = (j == 0);
      it.data = b;
      pending_bytes.insert(pending_bytes.size(), it);
    end
  endtask

  task automatic add_noise(int n);
    byte_item_t it;
    for (int i = 0; i < n; i++) begin
      it.start = 1'b0;
      it.data = 8'($urandom);
      pending_bytes.insert(pending_bytes.size(), it);
    end
  endtask

  task automatic random_frame();
    int ns, ng, cw, kind;
    logic [63:0] sm, cm;
    logic [31:0] gm;
    kind = $urandom_range(19);
    if (kind < 2) begin
      // well-formed frame cut short, abandoned by the next start
      ns = $urandom_range(3); ng = $urandom_range(3);
      build_frame(pick_bits(64, ns), 32'(pick_bits(32, ng)), '1, 0,
                  $urandom_range(1, 30));
    end else if (kind < 4) begin
      ns = $urandom_range(3, 64); ng = $urandom_range((MAX_CELL_CNT / ns) + 1, 32);
      build_frame(pick_bits(64, ns), 32'(pick_bits(32, ng)), '0, 0, 0);
    end else if (kind == 4) begin
      // full cell grid, sparse cell mask; both edge satellites present
      sm = pick_bits(64, 8);
      sm[0] = 1'b1; sm[63] = 1'b1;
      while ($countones(sm) > 8) sm[$urandom_range(1, 62)] = 1'b0;
      gm = 32'(pick_bits(32, 8));
      gm[0] = 1'b1; gm[31] = 1'b1;
      while ($countones(gm) > 8) gm[$urandom_range(1, 30)] = 1'b0;
      cm = pick_bits(64, 3);
      cm[0] = 1'b1; cm[63] = 1'b1;
      build_frame(sm, gm, cm, 0, 0);
    end else begin
      ns = $urandom_range(3); ng = $urandom_range(3);
      sm = pick_bits(64, ns);
      gm = 32'(pick_bits(32, ng));
      cw = ns * ng;
      cm = (cw == 0) ? '0 : rnd64() & ((64'd1 << cw) - 1);
      build_frame(sm, gm, cm, 0, 0);
    end
    if ($urandom_range(3) == 0) add_noise($urandom_range(1, 3));
  endtask

  initial begin
    byte_item_t it;
    acc_bits = '0; acc_count = 0; phase = PH_IDLE;
    sat_mask = '0; sig_mask = '0; cell_mask = '0; left_bits = '0; group_left = 0;
    // bytes before any start are ignored
    it.start = 1'b0; it.data = 8'h00; pending_bytes.insert(pending_bytes.size(), it);
    it.data = 8'hFF; pending_bytes.insert(pending_bytes.size(), it);
    build_frame('0, '0, '0, 2, 0);
    build_frame('1, '1, '0, 1, 0);
    build_frame(64'h3, 32'h1, '1, 1, 9);
    build_frame(64'h8000_0000_0000_0001, 32'h8000_0001, 64'hF, 1, 0);
    while (pending_bytes.size() < BYTE_TARGET) random_frame();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (err_count == 0 && expected_records.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // idling mode cycles every 40 bytes: none, sender, receiver, both
  function automatic bit hold_off(bit receiver);
    int mode;
    mode = (bytes_sent / 40) % 4;
    if (mode == 0) return 1'b0;
    if (mode == 3) return $urandom_range(99) < 20;
    if ((mode == 1) != receiver) return $urandom_range(99) < 74;
    return 1'b0;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || byte_taken) begin
        if (pending_bytes.size() == 0 || hold_off(1'b0)) begin
          s_tvalid <= 1'b0;
        end else begin
          next_byte = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= next_byte.data;
          s_tuser <= next_byte.start;
          bytes_sent++;
        end
      end
      m_tready <= !hold_off(1'b1);
    end
  end

  always @(posedge clk) begin
    record_t want, got;
    byte_taken <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        got.code = m_tuser;
        got.sat = m_tdata[6:0];
        got.sig = m_tdata[12:7];
        got.value = m_tdata[76:13];
        got.last = m_tlast;
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected word code=%0d sat=%0d sig=%0d value=%h last=%b",
                   $time, got.code, got.sat, got.sig, got.value, got.last);
          err_count++;
        end else begin
          want = expected_records.pop_front();
          if (got != want) begin
            $display("%0t: expected code=%0d sat=%0d sig=%0d value=%h last=%b",
                     $time, want.code, want.sat, want.sig, want.value, want.last);
            $display("%0t: actual   code=%0d sat=%0d sig=%0d value=%h last=%b",
                     $time, got.code, got.sat, got.sig, got.value, got.last);
            err_count++;
          end
        end
      end
    end
  end

endmodule
